[rtl/tlru_pkg.sv]
// Shared types and constants for the timestamp LRU tag store.
package tlru_pkg;

   localparam int ENTRIES     = 16;
   localparam int STAMP_BITS  = 32;
   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int HANDLE_BITS = 64;
   localparam int PROC_BITS   = 32;
   localparam int SLOT_BITS   = 4;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [PROC_BITS-1:0]   process_id;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      logic                 flushed;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [PROC_BITS-1:0]   process_id;
      logic [STAMP_BITS-1:0]  stamp;
   } entry_type;

   typedef struct packed {
      logic                scan;
      logic                update;
      logic [IDX_BITS-1:0] idx;
   } head_ctl_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] pick;
   } head_sts_type;

endpackage

[rtl/timestamp_lru_tag_store.sv]
// Top level of the timestamp LRU tag store: ring of entry cells, head unit and control.
//
// Usage: a request word carries a (handle, process_id) key; each request yields
// exactly one response word with hit, slot and flushed. Both channels use
// valid/ready and a word moves when both are high.
// Each lookup advances the stamp counter; a wrap to zero clears every stored
// handle. A hit restamps the matching entry; a miss advances the counter once
// more and overwrites the first entry holding the smallest stamp.
// Entries live in a ring of ENTRIES cells that rotates one place per cycle,
// while a pass runs, past a single compare unit at the head. One pass around
// the ring searches for the key and the least stamp, a second pass writes back.
// A request goes through the scan, decide, update and done states and back to
// idle; only one request is in work at a time, so a new request is taken only
// once the last one has reached idle again.
// The response sits in an output register: if the receiver stalls, the block
// still takes and processes the next request and then holds until that
// register is free.
// Reset is synchronous: all entries and the counter clear to zero, no response
// is pending, and a request can be taken in the first cycle after reset.
module timestamp_lru_tag_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlru_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlru_pkg::rsp_type rsp_data
);
   import tlru_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ENTRIES - 1);

   logic [2:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   req_type               key_ff, key_in;
   logic [STAMP_BITS-1:0] counter_ff, counter_in;
   logic                  wrapped_ff, wrapped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [STAMP_BITS-1:0] counter_inc;
   logic                  req_accept;
   logic                  rsp_load;
   logic                  shift;
   logic                  flush;

   head_ctl_type          head_ctl;
   head_sts_type          head_sts;
   entry_type             cell_q [ENTRIES];
   entry_type             wb_entry;

   assign counter_inc = counter_ff + 1'b1;
   assign req_ready   = (state_ff == S_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign rsp_load    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign shift       = (state_ff == S_SCAN) || (state_ff == S_UPDATE);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      counter_in = counter_ff;
      wrapped_in = wrapped_ff;
      flush      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in     = req_data;
               counter_in = counter_inc;
               flush      = (counter_inc == '0);
               wrapped_in = (counter_inc == '0);
               idx_in     = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // miss takes a second stamp before the victim is written
            if (!head_sts.found) begin
               counter_in = counter_inc;
               flush      = (counter_inc == '0);
               wrapped_in = wrapped_ff || (counter_inc == '0);
            end
            idx_in   = '0;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_in.hit     = head_sts.found;
         rsp_in.slot    = SLOT_BITS'(head_sts.pick);
         rsp_in.flushed = wrapped_ff;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         counter_ff   <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         counter_ff   <= counter_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign head_ctl.scan   = (state_ff == S_SCAN);
   assign head_ctl.update = (state_ff == S_UPDATE);
   assign head_ctl.idx    = idx_ff;

   tlru_head u_head (
      .clock      (clock),
      .reset      (reset),
      .ctl        (head_ctl),
      .key        (key_ff),
      .stamp      (counter_ff),
      .head_entry (cell_q[0]),
      .wb_entry   (wb_entry),
      .sts        (head_sts)
   );

   // cell i takes from cell i+1; the tail takes the head word after write-back
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      entry_type cell_d;
      if (g == ENTRIES - 1) begin : g_tail
         assign cell_d = wb_entry;
      end else begin : g_body
         assign cell_d = cell_q[g+1];
      end
      tlru_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .flush     (flush),
         .entry_in  (cell_d),
         .entry_out (cell_q[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_flush_on_wrap: assert property (@(posedge clock) disable iff (reset)
      flush |=> (counter_ff == '0))
      else $error("handle flush without counter wrap");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_SCAN) && (idx_ff == '0))
      else $error("accepted request did not start a scan pass");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside of completion");

endmodule

[rtl/tlru_cell.sv]
// Ring cell: holds one entry; shift loads the neighbor's, else flush clears the handle.
module tlru_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                flush,
   input  tlru_pkg::entry_type entry_in,
   output tlru_pkg::entry_type entry_out
);
   import tlru_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end else if (flush) begin
         entry_ff.handle <= '0;
      end
   end

   assign entry_out = entry_ff;

endmodule

[rtl/tlru_head.sv]
// Ring head: key match, least-stamp tracking and write-back of the selected entry.
module tlru_head (
   input  logic                         clock,
   input  logic                         reset,
   input  tlru_pkg::head_ctl_type       ctl,
   input  tlru_pkg::req_type            key,
   input  logic [tlru_pkg::STAMP_BITS-1:0] stamp,
   input  tlru_pkg::entry_type          head_entry,
   output tlru_pkg::entry_type          wb_entry,
   output tlru_pkg::head_sts_type       sts
);
   import tlru_pkg::*;

   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   match_ff, match_in;
   logic [STAMP_BITS-1:0] min_ff, min_in;
   logic [IDX_BITS-1:0]   minpick_ff, minpick_in;
   logic                  first;
   logic                  key_eq;
   logic [IDX_BITS-1:0]   pick;

   assign first  = (ctl.idx == '0);
   assign key_eq = (head_entry.handle == key.handle) &&
                   (head_entry.process_id == key.process_id);

   always_comb begin
      found_in   = found_ff;
      match_in   = match_ff;
      min_in     = min_ff;
      minpick_in = minpick_ff;
      if (ctl.scan) begin
         // first word of the pass restarts both searches
         if (key_eq && (first || !found_ff)) begin
            found_in = 1'b1;
            match_in = ctl.idx;
         end else if (first) begin
            found_in = 1'b0;
         end
         if (first || (head_entry.stamp < min_ff)) begin
            min_in     = head_entry.stamp;
            minpick_in = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         match_ff   <= '0;
         min_ff     <= '0;
         minpick_ff <= '0;
      end else begin
         found_ff   <= found_in;
         match_ff   <= match_in;
         min_ff     <= min_in;
         minpick_ff <= minpick_in;
      end
   end

   assign pick = found_ff ? match_ff : minpick_ff;

   always_comb begin
      wb_entry = head_entry;
      if (ctl.update && (ctl.idx == pick)) begin
         wb_entry.stamp = stamp;
         if (!found_ff) begin
            wb_entry.handle     = key.handle;
            wb_entry.process_id = key.process_id;
         end
      end
   end

   assign sts.found = found_ff;
   assign sts.pick  = pick;

endmodule

[verif/timestamp_lru_tag_store_tb.sv]
// Self-checking testbench for the timestamp LRU tag store: lookup traffic, shadow store, scoreboard.
`timescale 1ns / 100ps

module timestamp_lru_tag_store_tb;
   import tlru_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int RANDOM_WORDS = 2000;
   localparam int POOL_SIZE    = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 80;

   // Shadow of the tag store; predicts one reply per lookup and checks replies in order.
   class tag_store_mirror;
      logic [HANDLE_BITS-1:0] handle_q [ENTRIES];
      logic [PROC_BITS-1:0]   proc_q   [ENTRIES];
      logic [STAMP_BITS-1:0]  stamp_q  [ENTRIES];
      logic [STAMP_BITS-1:0]  stamp_now;
      rsp_type                expected_replies [$];
      int                     faults;

      function new();
         foreach (handle_q[i]) begin
            handle_q[i] = '0;
            proc_q[i]   = '0;
            stamp_q[i]  = '0;
         end
         stamp_now = '0;
         faults    = 0;
      endfunction

      // wrap to zero drops every stored handle; stamps stay
      function logic [STAMP_BITS-1:0] bump_stamp(inout logic wrapped);
         stamp_now = stamp_now + 1'b1;
         if (stamp_now == '0) begin
            foreach (handle_q[i]) handle_q[i] = '0;
            wrapped = 1'b1;
         end
         return stamp_now;
      endfunction

      function void note_lookup(req_type w);
         rsp_type               r;
         logic [STAMP_BITS-1:0] st;
         logic                  found;
         logic                  wrapped;
         int                    pick;
         found   = 1'b0;
         wrapped = 1'b0;
         pick    = 0;
         st = bump_stamp(wrapped);
         for (int i = 0; i < ENTRIES; i++) begin
            if (!found && handle_q[i] == w.handle && proc_q[i] == w.process_id) begin
               pick  = i;
               found = 1'b1;
            end
         end
         if (found) begin
            stamp_q[pick] = st;
         end else begin
            st = bump_stamp(wrapped);
            // first entry with the least stamp
            for (int i = 1; i < ENTRIES; i++) begin
               if (stamp_q[i] < stamp_q[pick]) pick = i;
            end
            stamp_q[pick]  = st;
            proc_q[pick]   = w.process_id;
            handle_q[pick] = w.handle;
         end
         r.hit     = found;
         r.slot    = SLOT_BITS'(pick);
         r.flushed = wrapped;
         expected_replies = {expected_replies, r};
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: reply word with no lookup pending: hit=%0d slot=%0d flushed=%0d",
                        $realtime, got.hit, got.slot, got.flushed);
            return;
         end
         want = expected_replies.pop_front();
         if (got.hit !== want.hit || got.slot !== want.slot || got.flushed !== want.flushed) begin
            faults++;
            if (faults <= 10)
               $display("%0t: reply mismatch: expected hit=%0d slot=%0d flushed=%0d, got hit=%0d slot=%0d flushed=%0d",
                        $realtime, want.hit, want.slot, want.flushed,
                        got.hit, got.slot, got.flushed);
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   tag_store_mirror mirror;
   req_type         key_pool [POOL_SIZE];
   logic            quiet;
   logic            hold_request;
   int              hold_left;
   int              cycle_count;

   timestamp_lru_tag_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // reply checked before the new lookup is noted: a reply on the same edge is older
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) mirror.check_reply(rsp_data);
         if (req_valid && req_ready) mirror.note_lookup(req_data);
      end
   end

   // receiver: random stalls, plus a long hold-off per hold_request so the block backs up
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
         if (hold_left == 0) hold_request = 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 8);
      end
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_lookup(input req_type w);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic req_type fresh_key();
      req_type w;
      w = {$urandom, $urandom, $urandom};
      return w;
   endfunction

   // mostly reuse of a working set, with near-miss keys, zero handles and noise mixed in
   function automatic req_type pool_key(int span);
      req_type w;
      int      sel;
      sel = $urandom_range(99);
      w   = key_pool[$urandom_range(span - 1)];
      if (sel < 8) begin
         w = fresh_key();
      end else if (sel < 13) begin
         w.handle = '0;
         if (sel < 10) w.process_id = '0;
      end else if (sel < 17) begin
         w.process_id = w.process_id ^ (32'h1 << $urandom_range(31));
      end else if (sel < 21) begin
         w.handle = w.handle ^ (64'h1 << $urandom_range(63));
      end
      return w;
   endfunction

   initial begin
      int span;
      mirror       = new();
      cycle_count  = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      hold_left    = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero handle against the cleared entries, field extremes, pid as part of the key
      send_lookup('{64'h0, 32'h0});
      send_lookup('{64'h0, 32'hFFFF_FFFF});
      send_lookup('{64'hFFFF_FFFF_FFFF_FFFF, 32'h0});
      send_lookup('{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF});
      send_lookup('{64'h1, 32'h1});
      send_lookup('{64'h8000_0000_0000_0000, 32'h8000_0000});
      send_lookup('{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555});
      send_lookup('{64'h5555_5555_5555_5555, 32'hAAAA_AAAA});
      send_lookup('{64'hFFFF_FFFF_FFFF_FFFF, 32'h0});
      send_lookup('{64'hFFFF_FFFF_FFFF_FFFF, 32'h1});
      send_lookup('{64'h1, 32'h1});
      // overflow the store so the least recent entries get replaced
      for (int i = 0; i < 12; i++)
         send_lookup('{64'h100 + i, 32'(i)});
      send_lookup('{64'h0, 32'h0});

      foreach (key_pool[i]) key_pool[i] = fresh_key();
      for (int i = 0; i < 4; i++) key_pool[i + 12].handle = key_pool[i].handle;
      span = 16;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 800 && n < 1100);
         if (n == 400 || n == 1500) hold_request = 1'b1;
         if (n % 250 == 249) begin
            repeat (4) key_pool[$urandom_range(POOL_SIZE - 1)] = fresh_key();
         end
         if (n % 100 == 0) begin
            case ($urandom_range(3))
               0: span = 8;
               1: span = 16;
               2: span = 17;
               default: span = POOL_SIZE;
            endcase
         end
         send_lookup(pool_key(span));
      end
      req_valid <= 1'b0;

      while (mirror.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.faults == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
rtl/tlru_pkg.sv
rtl/tlru_cell.sv
rtl/tlru_head.sv
rtl/timestamp_lru_tag_store.sv
verif/timestamp_lru_tag_store_tb.sv
